/* hdl/pprs_pkg.sv */
// Package for the priority pending request select block: constants, types and states.
package pprs_pkg;

   localparam int ID_COUNT = 256;
   localparam int IMP_BITS = 8;
   localparam int ID_BITS  = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;

   localparam logic [IMP_BITS-1:0] IMP_MAX = '1;

   typedef enum logic {
      CMD_SUBMIT = 1'b0,
      CMD_STATUS = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // One table update, applied at the edge at which an item is accepted.
   typedef struct packed {
      logic                en;
      logic                is_status;
      logic [ID_BITS-1:0]  idx;
      logic [IMP_BITS-1:0] importance;
      logic                done;
   } tbl_upd_type;

   // One entry as read out during the scan, in the cycle after its address.
   typedef struct packed {
      logic                valid;
      logic [ID_BITS-1:0]  id;
      logic                eligible;
      logic [IMP_BITS-1:0] importance;
   } tbl_rd_type;

endpackage

/* hdl/priority_pending_request_select_core.sv */
// Top level of the priority pending request select block: handshakes and scan sequencer.
//
// Each item updates at most one table entry when it is accepted, then the sequencer walks
// all ID_COUNT entries through one table read port and one shared compare unit, one entry
// per cycle, to find the pending id of highest importance (ties go to the larger id).
// An item goes through these steps: it is accepted, each entry is read in turn, the read
// register is drained, and the result register is loaded once the rsp side is free. The
// block takes no item until then. The result register lets a new item be accepted while
// the previous result still waits on the rsp side. Reset clears the present marks at once.
module priority_pending_request_select_core
   import pprs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_cmd,
   input  logic [7:0] req_req_id,
   input  logic [7:0] req_req_importance,
   input  logic       req_done_flag,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_next_valid,
   output logic [7:0] rsp_next_id,
   output logic       rsp_status_hit
);

   state_type          state_ff, state_in;
   logic [ID_BITS-1:0] addr_ff, addr_in;
   logic               hit_ff, hit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_next_valid_ff;
   logic [7:0]         rsp_next_id_ff;
   logic               rsp_status_hit_ff;

   logic               accept;
   logic               in_range;
   logic               last_addr;
   logic               rsp_free;
   logic               rd_en;
   logic               scan_clear;
   logic               load_rsp;
   logic [IMP_BITS-1:0] imp_sat;
   logic               upd_present;
   logic               found;
   logic [ID_BITS-1:0] best_id;
   tbl_upd_type        upd;
   tbl_rd_type         rd;

   assign accept    = req_valid && req_ready;
   assign in_range  = 32'(req_req_id) < ID_COUNT;
   assign last_addr = addr_ff == ID_BITS'(ID_COUNT - 1);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign imp_sat   = (32'(req_req_importance) > 32'(IMP_MAX)) ? IMP_MAX
                                                               : IMP_BITS'(req_req_importance);

   assign upd.en         = accept && in_range;
   assign upd.is_status  = req_cmd == CMD_STATUS;
   assign upd.idx        = ID_BITS'(req_req_id);
   assign upd.importance = imp_sat;
   assign upd.done       = req_done_flag;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SCAN;
         ST_SCAN:   if (last_addr) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready  = 1'b0;
      rd_en      = 1'b0;
      scan_clear = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            scan_clear = 1'b1;
         end
         ST_SCAN:   rd_en = 1'b1;
         ST_DRAIN:  ;
         ST_FINISH: load_rsp = rsp_free;
         default:   ;
      endcase
   end

   always_comb begin
      addr_in = addr_ff;
      if (accept) begin
         addr_in = '0;
      end else if (rd_en) begin
         addr_in = addr_ff + ID_BITS'(1);
      end
   end

   assign hit_in = accept ? (upd.is_status && in_range && upd_present) : hit_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      hit_ff  <= hit_in;
      if (load_rsp) begin
         rsp_next_valid_ff <= found;
         rsp_next_id_ff    <= found ? 8'(best_id) : 8'd0;
         rsp_status_hit_ff <= hit_ff;
      end
   end

   pprs_table u_table (
      .clock       (clock),
      .reset       (reset),
      .upd         (upd),
      .upd_present (upd_present),
      .rd_en       (rd_en),
      .rd_addr     (addr_ff),
      .rd          (rd)
   );

   pprs_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .clear   (scan_clear),
      .rd      (rd),
      .found   (found),
      .best_id (best_id)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_valid = rsp_next_valid_ff;
   assign rsp_next_id    = rsp_next_id_ff;
   assign rsp_status_hit = rsp_status_hit_ff;

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_SCAN && addr_ff == '0)
      else $error("accepted item did not start a scan at entry zero");

   a_none_reports_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_next_valid |-> rsp_next_id == 8'd0)
      else $error("result with nothing pending carries a nonzero id");

   a_finish_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |-> !rd.valid)
      else $error("result loaded while a table read is still in flight");

endmodule

/* hdl/pprs_table.sv */
// Request table: present marks in flip-flops, pending marks and importance in memories.
module pprs_table
   import pprs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  tbl_upd_type        upd,
   output logic               upd_present,
   input  logic               rd_en,
   input  logic [ID_BITS-1:0] rd_addr,
   output tbl_rd_type         rd
);

   logic [ID_COUNT-1:0] present_ff, present_in;
   logic                pending_mem [ID_COUNT];
   logic [IMP_BITS-1:0] imp_mem [ID_COUNT];
   logic                pend_wr;
   logic                pend_val;
   logic [IMP_BITS-1:0] rd_imp_ff;
   logic                rd_pend_ff;
   logic                rd_valid_ff;
   logic [ID_BITS-1:0]  rd_id_ff;
   logic                rd_pres_ff;

   assign upd_present = present_ff[upd.idx];

   always_comb begin
      present_in = present_ff;
      if (upd.en && !upd.is_status) begin
         present_in[upd.idx] = 1'b1;
      end
   end

   // A status item changes the pending mark only of a present id.
   assign pend_wr  = upd.en && (!upd.is_status || upd_present);
   assign pend_val = !upd.is_status || !upd.done;

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff  <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         present_ff  <= present_in;
         rd_valid_ff <= rd_en;
      end
   end

   // Importance and pending marks are read for every scanned id; eligibility also needs the present mark.
   always_ff @(posedge clock) begin
      if (upd.en && !upd.is_status) begin
         imp_mem[upd.idx] <= upd.importance;
      end
      if (pend_wr) begin
         pending_mem[upd.idx] <= pend_val;
      end
      if (rd_en) begin
         rd_imp_ff  <= imp_mem[rd_addr];
         rd_pend_ff <= pending_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_id_ff   <= rd_addr;
         rd_pres_ff <= present_ff[rd_addr];
      end
   end

   assign rd.valid      = rd_valid_ff;
   assign rd.id         = rd_id_ff;
   assign rd.eligible   = rd_pres_ff && rd_pend_ff;
   assign rd.importance = rd_imp_ff;

   a_submit_sets_marks: assert property (@(posedge clock) disable iff (reset)
      upd.en && !upd.is_status |=> present_ff[$past(upd.idx)] && pending_mem[$past(upd.idx)])
      else $error("submitted entry is not present and pending");

endmodule

/* hdl/pprs_scan.sv */
// Shared compare unit that keeps the best pending entry seen during a scan.
module pprs_scan
   import pprs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  tbl_rd_type         rd,
   output logic               found,
   output logic [ID_BITS-1:0] best_id
);

   logic                found_ff, found_in;
   logic [ID_BITS-1:0]  best_id_ff, best_id_in;
   logic [IMP_BITS-1:0] best_imp_ff, best_imp_in;
   logic                take;

   // Ids arrive in ascending order, so taking equal importance favors the larger id.
   assign take = rd.valid && rd.eligible && (!found_ff || (rd.importance >= best_imp_ff));

   always_comb begin
      found_in    = found_ff;
      best_id_in  = best_id_ff;
      best_imp_in = best_imp_ff;
      if (clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in    = 1'b1;
         best_id_in  = rd.id;
         best_imp_in = rd.importance;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_id_ff  <= best_id_in;
      best_imp_ff <= best_imp_in;
   end

   assign found   = found_ff;
   assign best_id = best_id_ff;

   a_found_after_eligible: assert property (@(posedge clock) disable iff (reset)
      !clear && rd.valid && rd.eligible |=> found_ff)
      else $error("eligible entry seen but nothing found");

endmodule
